>>> hdl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, codes and helpers for the texture palettize and pack block.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 16;
  localparam int COUNT_W           = 9;
  localparam int GROUP_SIZE        = 8;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_PACK  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] FMT_2BPP   = 2'd0;
  localparam logic [1:0] FMT_4BPP   = 2'd1;
  localparam logic [1:0] FMT_8BPP   = 2'd2;
  localparam logic [1:0] FMT_DIRECT = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [COLOR_W-1:0] pixel;
    logic               last_in_row;
    logic [7:0]         entry_index;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] packed_halfword;
    logic               halfword_valid;
    logic               row_end;
    logic [COUNT_W-1:0] entry_count;
    logic               overflowed;
    logic [1:0]         format_code;
    logic [COLOR_W-1:0] palette_entry;
  } out_t;

  typedef struct packed {
    logic               read_mode;
    logic               wr_en;
    logic [COUNT_W-1:0] used;
    logic [COLOR_W-1:0] color;
    logic [7:0]         rd_idx;
  } cell_ctrl_t;

  function automatic logic [1:0] format_of(input logic ovf, input logic [COUNT_W-1:0] used);
    logic [1:0] fmt;
    if (ovf) begin
      fmt = FMT_DIRECT;
    end else if (used <= COUNT_W'(4)) begin
      fmt = FMT_2BPP;
    end else if (used <= COUNT_W'(16)) begin
      fmt = FMT_4BPP;
    end else begin
      fmt = FMT_8BPP;
    end
    return fmt;
  endfunction

endpackage

>>> hdl/tpp_cell.sv
// ----------------------------------------------------------------------------
// tpp_cell
// One palette entry with its own color match and address match.
// ----------------------------------------------------------------------------
module tpp_cell #(
  parameter int CELL_IDX = 1
) (
  input  logic                                 clk,
  input  tpp_pkg::cell_ctrl_t                  ctrl,
  output logic [tpp_pkg::COLOR_W-1:0]          word_o
);
  import tpp_pkg::*;

  localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(CELL_IDX);

  logic [COLOR_W-1:0] entry_r;
  logic [COLOR_W-1:0] word_r;
  logic [COLOR_W-1:0] word_nxt;
  logic               in_use;

  assign in_use = (ctrl.used > IDX_C);

  always_comb begin
    word_nxt = '0;
    if (ctrl.read_mode) begin
      if (in_use && (COUNT_W'(ctrl.rd_idx) == IDX_C)) begin
        word_nxt = entry_r;
      end
    end else if (in_use && (entry_r == ctrl.color)) begin
      word_nxt = COLOR_W'(IDX_C);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.used == IDX_C)) begin
      entry_r <= ctrl.color;
    end
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

>>> hdl/tpp_row.sv
// ----------------------------------------------------------------------------
// tpp_row
// Row of palette cells and the registered OR tree that merges their words.
// ----------------------------------------------------------------------------
module tpp_row #(
  parameter int PALETTE_DEPTH = tpp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                        clk,
  input  tpp_pkg::cell_ctrl_t         ctrl,
  output logic [tpp_pkg::COLOR_W-1:0] sum_o
);
  import tpp_pkg::*;

  localparam int NGRP  = (PALETTE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NSLOT = NGRP * GROUP_SIZE;

  logic [COLOR_W-1:0] words [NSLOT];
  logic [COLOR_W-1:0] grp_nxt [NGRP];
  logic [COLOR_W-1:0] grp_r [NGRP];
  logic [COLOR_W-1:0] sum_nxt;
  logic [COLOR_W-1:0] sum_r;

  for (genvar i = 0; i < NSLOT; i++) begin : g_slot
    if ((i >= 1) && (i < PALETTE_DEPTH)) begin : g_cell
      tpp_cell #(.CELL_IDX(i)) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .word_o (words[i])
      );
    end else begin : g_empty
      assign words[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] | words[g*GROUP_SIZE + k];
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_nxt = sum_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
    sum_r <= sum_nxt;
  end

  assign sum_o = sum_r;

endmodule

>>> hdl/texture_palettize_pack_top.sv
// ----------------------------------------------------------------------------
// texture_palettize_pack_top
// Palette builder and index packer for 16-bit texture pixels.
//
//   channel   dir   ports                              payload
//   in        in    in_valid, in_stall, in_data        tpp_pkg::in_t
//   out       out   out_valid, out_stall, out_data     tpp_pkg::out_t
//
// Each item passes through the transfer, the compare in every palette cell,
// the group merge, the final merge and the state update, which registers
// the result. One item is in flight.
// Reset clears control state only; entries at or above the count are never read.
// A waiting result holds the update step until out_stall drops.
// ----------------------------------------------------------------------------
module texture_palettize_pack_top #(
  parameter int PALETTE_DEPTH = tpp_pkg::PALETTE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tpp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tpp_pkg::out_t  out_data
);
  import tpp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CELL  = 5'b00010,
    ST_GROUP = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  in_t                item_r;
  logic [COUNT_W-1:0] used_r, used_nxt;
  logic               ovf_r, ovf_nxt;
  logic [COLOR_W-1:0] acc_r, acc_nxt;
  logic [2:0]         fill_r, fill_nxt;
  logic               out_valid_r;
  out_t               out_data_r;
  out_t               res;

  cell_ctrl_t         ctrl;
  logic [COLOR_W-1:0] sum;
  logic               accept;
  logic               fin_go;
  logic               wr_en;
  logic [1:0]         fmt;
  logic [7:0]         idx_src;
  logic [7:0]         idx_m;
  logic [5:0]         shift;
  logic [COLOR_W-1:0] acc_or;
  logic [3:0]         fill_inc;
  logic [3:0]         per;
  logic               emit;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign ctrl.read_mode = (item_r.command == CMD_READ);
  assign ctrl.wr_en     = wr_en && fin_go;
  assign ctrl.used      = used_r;
  assign ctrl.color     = item_r.pixel;
  assign ctrl.rd_idx    = item_r.entry_index;

  tpp_row #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_row (
    .clk   (clk),
    .ctrl  (ctrl),
    .sum_o (sum)
  );

  assign fmt     = format_of(ovf_r, used_r);
  assign idx_src = item_r.pixel[COLOR_W-1] ? sum[7:0] : 8'd0;

  always_comb begin
    case (fmt)
      FMT_2BPP: begin
        idx_m = idx_src & 8'h03;
        shift = {2'b00, fill_r, 1'b0};
      end
      FMT_4BPP: begin
        idx_m = idx_src & 8'h0F;
        shift = {1'b0, fill_r, 2'b00};
      end
      default: begin
        idx_m = idx_src;
        shift = {fill_r, 3'b000};
      end
    endcase
  end

  assign acc_or   = acc_r | COLOR_W'(32'(idx_m) << shift);
  assign fill_inc = {1'b0, fill_r} + 4'd1;
  assign per      = 4'd8 >> fmt;
  assign emit     = (fill_inc >= per) || item_r.last_in_row;

  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    wr_en    = 1'b0;
    res      = '0;
    case (item_r.command)
      CMD_CLEAR: begin
        used_nxt = COUNT_W'(1);
        ovf_nxt  = 1'b0;
        acc_nxt  = '0;
        fill_nxt = '0;
      end
      CMD_SCAN: begin
        if (!ovf_r && item_r.pixel[COLOR_W-1] && (sum == '0)) begin
          if (used_r >= COUNT_W'(PALETTE_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            used_nxt = used_r + COUNT_W'(1);
          end
        end
      end
      CMD_PACK: begin
        if (fmt == FMT_DIRECT) begin
          res.packed_halfword = item_r.pixel;
          res.halfword_valid  = 1'b1;
          res.row_end         = item_r.last_in_row;
          acc_nxt             = '0;
          fill_nxt            = '0;
        end else if (emit) begin
          res.packed_halfword = acc_or;
          res.halfword_valid  = 1'b1;
          res.row_end         = item_r.last_in_row;
          acc_nxt             = '0;
          fill_nxt            = '0;
        end else begin
          acc_nxt  = acc_or;
          fill_nxt = fill_inc[2:0];
        end
      end
      default: begin
        res.palette_entry = sum;
      end
    endcase
    res.entry_count = used_nxt;
    res.overflowed  = ovf_nxt;
    res.format_code = format_of(ovf_nxt, used_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CELL;
      ST_CELL:  state_nxt = ST_GROUP;
      ST_GROUP: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= COUNT_W'(1);
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        used_r      <= used_nxt;
        ovf_r       <= ovf_nxt;
        acc_r       <= acc_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (fin_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/tpp_checker.sv
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks for the texture palettize and pack block.
// ----------------------------------------------------------------------------
module tpp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input tpp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input tpp_pkg::out_t out_data
);
  import tpp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count != '0) && (out_data.entry_count <= COUNT_W'(256)))
    else $error("entry count out of range");

  a_ovf_direct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |-> out_data.format_code == FMT_DIRECT)
    else $error("overflow without direct format");

  a_small_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overflowed && (out_data.entry_count <= COUNT_W'(4))
      |-> out_data.format_code == FMT_2BPP)
    else $error("format does not follow entry count");

  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.halfword_valid
      |-> (out_data.packed_halfword == '0) && !out_data.row_end)
    else $error("halfword fields set without a halfword");

endmodule

bind texture_palettize_pack_top tpp_checker u_tpp_checker (.*);

>>> sim/texture_palettize_pack_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_palettize_pack_top_tb
// Self-checking bench for the palette builder and index packer. A short
// directed table covers reset values, the transparent index, palette growth,
// 2/4-bit packing, unknown colors and reads past the count. Random uploads
// follow: clear, scan a color set sized for each format (overflow included),
// then pack rows of pixels, mixed with reads, stray scans and noise. Each
// result is checked against its table row or the behavioral palette/packer.
// ----------------------------------------------------------------------------
module texture_palettize_pack_top_tb;
  import tpp_pkg::*;

  localparam int TOTAL_ITEMS = 1425;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t        pending_results[$];
  dir_row_t    dir_rows[$];
  int          items_sent     = 0;
  int          fail_count     = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 31;
  int          recv_stall_pct = 62;

  // palette and packer state of the bench
  logic [15:0] pal_color [256];
  int unsigned pal_used;
  bit          pal_overflow;
  logic [15:0] pack_acc;
  int unsigned pack_fill;

  texture_palettize_pack_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** texture_palettize_pack_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [1:0] palette_format();
    logic [1:0] fmt;
    if (pal_overflow) begin
      fmt = FMT_DIRECT;
    end else if (pal_used <= 4) begin
      fmt = FMT_2BPP;
    end else if (pal_used <= 16) begin
      fmt = FMT_4BPP;
    end else begin
      fmt = FMT_8BPP;
    end
    return fmt;
  endfunction

  // index of a matching entry at 1 and up, 0 when absent
  function automatic int unsigned lookup_color(input logic [15:0] color);
    for (int unsigned i = 1; i < pal_used && i < 256; i++) begin
      if (pal_color[i] == color) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic void palette_clear_all();
    foreach (pal_color[i]) begin
      pal_color[i] = '0;
    end
    pal_used     = 1;
    pal_overflow = 1'b0;
    pack_acc     = '0;
    pack_fill    = 0;
  endfunction

  function automatic out_t palettize_step(input in_t it);
    out_t        r;
    logic [1:0]  fmt;
    int unsigned bits;
    int unsigned per;
    int unsigned idx;
    int unsigned shift;
    r = '0;
    case (it.command)
      CMD_CLEAR: begin
        pal_color[0] = '0;
        pal_used     = 1;
        pal_overflow = 1'b0;
        pack_acc     = '0;
        pack_fill    = 0;
      end
      CMD_SCAN: begin
        if (!pal_overflow && it.pixel[15] && lookup_color(it.pixel) == 0) begin
          if (pal_used >= 256) begin
            pal_overflow = 1'b1;
          end else begin
            pal_color[pal_used] = it.pixel;
            pal_used++;
          end
        end
      end
      CMD_PACK: begin
        fmt = palette_format();
        if (fmt == FMT_DIRECT) begin
          r.packed_halfword = it.pixel;
          r.halfword_valid  = 1'b1;
          r.row_end         = it.last_in_row;
          pack_acc          = '0;
          pack_fill         = 0;
        end else begin
          bits  = 2 << fmt;
          per   = 16 / bits;
          idx   = it.pixel[15] ? lookup_color(it.pixel) : 0;
          idx   = idx & ((1 << bits) - 1);
          shift = (pack_fill & 7) * bits;
          if (shift < 16) begin
            pack_acc = pack_acc | 16'(idx << shift);
          end
          pack_fill = (pack_fill + 1) & 15;
          if (pack_fill >= per || it.last_in_row) begin
            r.packed_halfword = pack_acc;
            r.halfword_valid  = 1'b1;
            r.row_end         = it.last_in_row;
            pack_acc          = '0;
            pack_fill         = 0;
          end
        end
      end
      default: begin
        if (it.entry_index < pal_used) begin
          r.palette_entry = pal_color[it.entry_index];
        end
      end
    endcase
    r.entry_count = 9'(pal_used);
    r.overflowed  = pal_overflow;
    r.format_code = palette_format();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("packed_halfword", want.packed_halfword, out_data.packed_halfword);
        check_field("halfword_valid", 16'(want.halfword_valid),
                    16'(out_data.halfword_valid));
        check_field("row_end", 16'(want.row_end), 16'(out_data.row_end));
        check_field("entry_count", 16'(want.entry_count), 16'(out_data.entry_count));
        check_field("overflowed", 16'(want.overflowed), 16'(out_data.overflowed));
        check_field("format_code", 16'(want.format_code), 16'(out_data.format_code));
        check_field("palette_entry", want.palette_entry, out_data.palette_entry);
      end
    end
  end

  task automatic send_item(input in_t it, input bit use_typed, input out_t typed);
    out_t predicted;
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct  = 31;
      recv_stall_pct = 62;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct  = 62;
      recv_stall_pct = 31;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = palettize_step(it);
    pending_results.push_back(use_typed ? typed : predicted);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] pix,
                          input logic last, input logic [7:0] idx);
    in_t it;
    it.command     = cmd;
    it.pixel       = pix;
    it.last_in_row = last;
    it.entry_index = idx;
    send_item(it, 1'b0, '0);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic dir_row_t row(input logic [1:0] cmd, input logic [15:0] pix,
                                   input logic last, input logic [7:0] idx, input bit chk,
                                   input logic [15:0] hw, input logic hv, input logic re,
                                   input logic [8:0] cnt, input logic [1:0] fmt,
                                   input logic [15:0] ent);
    dir_row_t r;
    r.stim.command          = cmd;
    r.stim.pixel            = pix;
    r.stim.last_in_row      = last;
    r.stim.entry_index      = idx;
    r.typed                 = chk;
    r.want.packed_halfword  = hw;
    r.want.halfword_valid   = hv;
    r.want.row_end          = re;
    r.want.entry_count      = cnt;
    r.want.overflowed       = 1'b0;
    r.want.format_code      = fmt;
    r.want.palette_entry    = ent;
    return r;
  endfunction

  // clear, scan a color set, then pack a small image and read entries back
  task automatic run_upload(input int kind);
    logic [15:0] colors[$];
    logic [15:0] pix;
    logic [14:0] base;
    logic [14:0] stride;
    int          ncol;
    int          w;
    int          h;
    int          pick;
    case (kind)
      0:       ncol = $urandom_range(0, 3);
      1:       ncol = $urandom_range(4, 15);
      2:       ncol = ($urandom_range(9) == 0) ? 255 : $urandom_range(16, 60);
      default: ncol = $urandom_range(256, 270);
    endcase
    base   = 15'($urandom);
    stride = 15'($urandom) | 15'd1;
    for (int i = 0; i < ncol; i++) begin
      colors.push_back({1'b1, 15'(base + 15'(i) * stride)});
    end
    send_cmd(CMD_CLEAR, 16'($urandom), 1'($urandom), 8'($urandom));
    for (int i = 0; i < ncol; i++) begin
      if ($urandom_range(9) == 0) begin
        send_cmd(CMD_SCAN, {1'b0, 15'($urandom)}, 1'($urandom), 8'($urandom));
      end
      send_cmd(CMD_SCAN, colors[i], 1'($urandom), 8'($urandom));
      if (i > 0 && $urandom_range(4) == 0) begin
        send_cmd(CMD_SCAN, colors[$urandom_range(0, i - 1)], 1'($urandom), 8'($urandom));
      end
    end
    w = $urandom_range(1, 12);
    h = $urandom_range(1, 5);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        pick = $urandom_range(99);
        if (ncol == 0 || pick < 10) begin
          pix = {1'b0, 15'($urandom)};
        end else if (pick < 18) begin
          pix = {1'b1, 15'($urandom)};
        end else begin
          pix = colors[$urandom_range(0, ncol - 1)];
        end
        if ($urandom_range(29) == 0) begin
          send_cmd(CMD_READ, 16'($urandom), 1'($urandom), 8'($urandom));
        end
        if ($urandom_range(39) == 0) begin
          send_cmd(CMD_SCAN, {1'b1, 15'($urandom)}, 1'($urandom), 8'($urandom));
        end
        send_cmd(CMD_PACK, pix, (c == w - 1), 8'($urandom));
      end
    end
    repeat ($urandom_range(1, 4)) begin
      send_cmd(CMD_READ, 16'($urandom), 1'($urandom), 8'($urandom_range(0, ncol + 1)));
    end
  endtask

  initial begin
    int  kind;
    int  p;
    bit  first;
    palette_clear_all();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(row(CMD_READ, 16'h0000, 0, 8'd0,   1, 16'h0, 0, 0, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_READ, 16'hFFFF, 1, 8'd255, 1, 16'h0, 0, 0, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'h7FFF, 0, 8'd0,   1, 16'h0, 0, 0, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'hFFFF, 0, 8'd0,   1, 16'h0, 0, 0, 9'd2, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'h8000, 1, 8'd255, 1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'hFFFF, 0, 8'd0,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_READ, 16'h0000, 0, 8'd1,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'hFFFF));
    dir_rows.push_back(row(CMD_READ, 16'h0000, 0, 8'd2,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h8000));
    dir_rows.push_back(row(CMD_READ, 16'h0000, 0, 8'd3,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hFFFF, 0, 8'd0,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h8000, 0, 8'd0,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h0000, 0, 8'd0,   1, 16'h0, 0, 0, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h9999, 1, 8'd0,   1, 16'h9, 1, 1, 9'd3, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'hC000, 0, 8'd0,   1, 16'h0, 0, 0, 9'd4, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_SCAN, 16'hC001, 0, 8'd0,   1, 16'h0, 0, 0, 9'd5, FMT_4BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hC001, 1, 8'd0,   1, 16'h4, 1, 1, 9'd5, FMT_4BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hFFFF, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h7FFF, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hC000, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h8000, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hFFFF, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_CLEAR, 16'h0000, 0, 8'd0,  1, 16'h0, 0, 0, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'hFFFF, 1, 8'd0,   1, 16'h0, 1, 1, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_READ, 16'h0000, 0, 8'd1,   1, 16'h0, 0, 0, 9'd1, FMT_2BPP, 16'h0));
    dir_rows.push_back(row(CMD_PACK, 16'h8000, 0, 8'd0,   0, 16'h0, 0, 0, 9'd0, FMT_2BPP, 16'h0));

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_results_drained();

    first = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      p = $urandom_range(99);
      if (first) begin
        kind = 3;
      end else if (p < 30) begin
        kind = 0;
      end else if (p < 60) begin
        kind = 1;
      end else if (p < 80) begin
        kind = 2;
      end else if (p < 85) begin
        kind = 3;
      end else begin
        kind = 4;
      end
      first = 1'b0;
      if (kind == 4) begin
        repeat ($urandom_range(10, 30)) begin
          send_cmd(2'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
        end
      end else begin
        run_upload(kind);
      end
      if ($urandom_range(4) == 0) begin
        wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** texture_palettize_pack_top: PASSED **");
    end else begin
      $display("** texture_palettize_pack_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tpp_pkg.sv
hdl/tpp_cell.sv
hdl/tpp_row.sv
hdl/texture_palettize_pack_top.sv
hdl/tpp_checker.sv
sim/texture_palettize_pack_top_tb.sv
